// ----- hw/rtl/mte_pkg.sv -----
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, codes and defaults for the multimap table engine.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int CAPACITY_DEF = 32;

  typedef enum logic [1:0] {
    KIND_INSERT      = 2'd0,
    KIND_SEARCH      = 2'd1,
    KIND_REMOVE_PAIR = 2'd2,
    KIND_REMOVE_KEY  = 2'd3
  } kind_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
    logic               last;
    logic [5:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SRCH,
    S_FIND,
    S_SHIFT,
    S_SWEEP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       insert;
    logic       init_down;
    logic       init_up;
    logic       init_shift;
    logic       step_down;
    logic       step_up;
    logic       search_take;
    logic       copy_all;
    logic       copy_skip_key;
    logic       count_dec;
    logic       count_wptr;
    logic       set_status;
    logic [1:0] status;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic idx_at_count;
    logic rd_vld;
    logic key_hit;
    logic pair_hit;
    logic pend_vld;
    logic out_free;
    logic found;
  } sts_t;

endpackage

// ----- hw/rtl/mte_ctrl.sv -----
// ----------------------------------------------------------------------------
// mte_ctrl
// Request sequencer: picks the walk for each request kind and paces it.
// ----------------------------------------------------------------------------
module mte_ctrl
  import mte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_kind,
  output logic       req_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          unique case (kind_t'(req_kind))
            KIND_INSERT: begin
              state_next = S_INSERT;
            end
            KIND_SEARCH: begin
              cmd.init_down = 1'b1;
              state_next    = S_SRCH;
            end
            KIND_REMOVE_PAIR: begin
              cmd.init_down = 1'b1;
              state_next    = S_FIND;
            end
            KIND_REMOVE_KEY: begin
              cmd.init_up = 1'b1;
              state_next  = S_SWEEP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INSERT: begin
        cmd.set_status = 1'b1;
        if (sts.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.insert = 1'b1;
          cmd.status = ST_DONE;
        end
        state_next = S_EMIT;
      end
      S_SRCH: begin
        // hold the walk while a second hit waits for the output register
        if (!(sts.key_hit && sts.pend_vld && !sts.out_free)) begin
          cmd.step_down   = 1'b1;
          cmd.search_take = 1'b1;
          if (sts.idx_zero && !sts.rd_vld) begin
            cmd.set_status = 1'b1;
            cmd.status     = sts.pend_vld ? ST_DONE : ST_MISS;
            state_next     = S_EMIT;
          end
        end
      end
      S_FIND: begin
        if (sts.pair_hit) begin
          cmd.init_shift = 1'b1;
          state_next     = S_SHIFT;
        end else begin
          cmd.step_down = 1'b1;
          if (sts.idx_zero && !sts.rd_vld) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_MISS;
            state_next     = S_EMIT;
          end
        end
      end
      S_SHIFT: begin
        cmd.step_up  = 1'b1;
        cmd.copy_all = 1'b1;
        if (sts.idx_at_count && !sts.rd_vld) begin
          cmd.count_dec  = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_DONE;
          state_next     = S_EMIT;
        end
      end
      S_SWEEP: begin
        cmd.step_up       = 1'b1;
        cmd.copy_skip_key = 1'b1;
        if (sts.idx_at_count && !sts.rd_vld) begin
          cmd.count_wptr = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = sts.found ? ST_DONE : ST_MISS;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/mte_datapath.sv -----
// ----------------------------------------------------------------------------
// mte_datapath
// Pair store, walk pointers, compare, pending search hit and output register.
// ----------------------------------------------------------------------------
module mte_datapath
  import mte_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem_key [CAPACITY];
  logic signed [31:0] mem_val [CAPACITY];

  req_t               req_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      wptr;
  logic               rd_vld;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rkey;
  logic signed [31:0] rval;
  logic               pend_vld;
  logic signed [31:0] pend_val;
  logic               found;
  logic [1:0]         status_q;

  logic [CW-1:0]      idx_m1;
  logic               rd_en;
  logic [AW-1:0]      rd_addr_next;
  logic               key_eq;
  logic               val_eq;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_key;
  logic signed [31:0] wr_val;
  logic               out_free;
  logic               push_pend;

  assign idx_m1   = idx - 1'b1;
  assign key_eq   = (rkey == req_q.key);
  assign val_eq   = (rval == req_q.value);
  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    rd_en        = 1'b0;
    rd_addr_next = idx[AW-1:0];
    if (cmd.step_down && idx != '0) begin
      rd_en        = 1'b1;
      rd_addr_next = idx_m1[AW-1:0];
    end else if (cmd.step_up && idx != count) begin
      rd_en        = 1'b1;
      rd_addr_next = idx[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr[AW-1:0];
    wr_key  = rkey;
    wr_val  = rval;
    if (cmd.insert) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_key  = req_q.key;
      wr_val  = req_q.value;
    end else if (rd_vld && (cmd.copy_all || (cmd.copy_skip_key && !key_eq))) begin
      wr_en = 1'b1;
    end
  end

  assign push_pend = cmd.search_take && rd_vld && key_eq && pend_vld;

  always_comb begin
    sts.full         = (count >= CW'(CAPACITY));
    sts.idx_zero     = (idx == '0);
    sts.idx_at_count = (idx == count);
    sts.rd_vld       = rd_vld;
    sts.key_hit      = rd_vld && key_eq;
    sts.pair_hit     = rd_vld && key_eq && val_eq;
    sts.pend_vld     = pend_vld;
    sts.out_free     = out_free;
    sts.found        = found;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_val[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rkey    <= mem_key[rd_addr_next];
      rval    <= mem_val[rd_addr_next];
      rd_addr <= rd_addr_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      pend_vld  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + 1'b1;
      end else if (cmd.count_dec) begin
        count <= count - 1'b1;
      end else if (cmd.count_wptr) begin
        count <= wptr;
      end

      if (cmd.init_down || cmd.init_up || cmd.init_shift) begin
        rd_vld <= 1'b0;
      end else if (cmd.step_down || cmd.step_up) begin
        rd_vld <= rd_en;
      end

      if (cmd.init_down || cmd.emit) begin
        pend_vld <= 1'b0;
      end else if (cmd.search_take && rd_vld && key_eq) begin
        pend_vld <= 1'b1;
      end

      if (cmd.init_up) begin
        found <= 1'b0;
      end else if (cmd.copy_skip_key && rd_vld && key_eq) begin
        found <= 1'b1;
      end

      if (cmd.emit || push_pend) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end

    if (cmd.init_down) begin
      idx <= count;
    end else if (cmd.init_up) begin
      idx  <= '0;
      wptr <= '0;
    end else if (cmd.init_shift) begin
      wptr <= CW'(rd_addr);
      idx  <= CW'(rd_addr) + 1'b1;
    end else begin
      if (cmd.step_down && rd_en) begin
        idx <= idx_m1;
      end else if (cmd.step_up && rd_en) begin
        idx <= idx + 1'b1;
      end
      if (wr_en && !cmd.insert) begin
        wptr <= wptr + 1'b1;
      end
    end

    if (cmd.search_take && rd_vld && key_eq) begin
      pend_val <= rval;
    end

    if (cmd.set_status) begin
      status_q <= cmd.status;
    end

    if (cmd.emit) begin
      rsp.status      <= status_q;
      rsp.found_value <= pend_vld ? pend_val : 32'sd0;
      rsp.last        <= 1'b1;
      rsp.entry_count <= 6'(count);
      rsp.is_empty    <= (count == '0);
    end else if (push_pend) begin
      // older hit follows, so this one is not the last
      rsp.status      <= ST_DONE;
      rsp.found_value <= pend_val;
      rsp.last        <= 1'b0;
      rsp.entry_count <= 6'(count);
      rsp.is_empty    <= (count == '0);
    end
  end

endmodule

// ----- hw/rtl/multimap_table_engine.sv -----
// ----------------------------------------------------------------------------
// multimap_table_engine
// Fixed-capacity key/value multimap kept in insertion order.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken once the current one
// has queued its final response, and a response may still wait in the output
// register then. Pairs live in a one-read, one-write memory walked one entry
// per cycle, except that a search holds its walk while a second hit waits for
// the output register. Insert needs no walk; search and remove-all-of-key
// walk the stored pairs once, and remove-exact-pair walks down to find the
// newest match and then walks up to close the gap.
module multimap_table_engine
  import mte_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mte_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- hw/rtl/mte_checker.sv -----
// ----------------------------------------------------------------------------
// mte_checker
// Port-level checks on both channels, bound to the top level.
// ----------------------------------------------------------------------------
module mte_checker
  import mte_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // hold a stalled request
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_empty == (rsp.entry_count == 6'd0))
    else $error("empty flag disagrees with entry count");

  a_miss_full_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_DONE |-> rsp.last && rsp.found_value == 32'sd0)
    else $error("miss or full response not final or carries a value");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> !rsp.is_empty)
    else $error("full refusal on an empty table");

endmodule

bind multimap_table_engine mte_checker u_mte_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- test/mte_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mte_scoreboard
// Watches both channels of the multimap table engine, keeps its own copy of
// the stored pairs, predicts every response of each accepted request and
// compares the responses in order, field by field.
// ----------------------------------------------------------------------------
module mte_scoreboard
  import mte_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  logic signed [31:0] pair_key [CAPACITY];
  logic signed [31:0] pair_val [CAPACITY];
  int                 pair_count;
  rsp_t               expected_rsp [$];
  int                 mismatches;

  // Count and empty flag reflect the table after the request.
  function automatic rsp_t result_word(logic [1:0] status, logic signed [31:0] found,
                                       logic last);
    rsp_t r;
    r.status      = status;
    r.found_value = found;
    r.last        = last;
    r.entry_count = pair_count[5:0];
    r.is_empty    = (pair_count == 0);
    return r;
  endfunction

  task automatic predict_request(req_t r);
    int hits;
    int idx;
    int w;
    int i;
    bit any;
    case (r.kind)
      KIND_INSERT: begin
        if (pair_count >= CAPACITY) begin
          expected_rsp = {expected_rsp, result_word(ST_FULL, '0, 1'b1)};
        end else begin
          pair_key[pair_count] = r.key;
          pair_val[pair_count] = r.value;
          pair_count++;
          expected_rsp = {expected_rsp, result_word(ST_DONE, '0, 1'b1)};
        end
      end
      KIND_SEARCH: begin
        hits = 0;
        for (i = 0; i < pair_count; i++)
          if (pair_key[i] == r.key) hits++;
        if (hits == 0) begin
          expected_rsp = {expected_rsp, result_word(ST_MISS, '0, 1'b1)};
        end else begin
          // newest first, last marker on the oldest match
          for (i = pair_count - 1; i >= 0; i--) begin
            if (pair_key[i] == r.key) begin
              hits--;
              expected_rsp = {expected_rsp, result_word(ST_DONE, pair_val[i], hits == 0)};
            end
          end
        end
      end
      KIND_REMOVE_PAIR: begin
        idx = -1;
        for (i = 0; i < pair_count; i++)
          if (pair_key[i] == r.key && pair_val[i] == r.value) idx = i;
        if (idx < 0) begin
          expected_rsp = {expected_rsp, result_word(ST_MISS, '0, 1'b1)};
        end else begin
          for (i = idx; i < pair_count - 1; i++) begin
            pair_key[i] = pair_key[i + 1];
            pair_val[i] = pair_val[i + 1];
          end
          pair_count--;
          expected_rsp = {expected_rsp, result_word(ST_DONE, '0, 1'b1)};
        end
      end
      KIND_REMOVE_KEY: begin
        w   = 0;
        any = 1'b0;
        for (i = 0; i < pair_count; i++) begin
          if (pair_key[i] == r.key) begin
            any = 1'b1;
          end else begin
            pair_key[w] = pair_key[i];
            pair_val[w] = pair_val[i];
            w++;
          end
        end
        pair_count = w;
        expected_rsp = {expected_rsp, result_word(any ? ST_DONE : ST_MISS, '0, 1'b1)};
      end
      default: ;
    endcase
  endtask

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      pair_count = 0;
      mismatches = 0;
      expected_rsp.delete();
    end else begin
      // Compare before predicting: a request never answers in its own cycle.
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: response with nothing expected, expected none, got %h", $time, rsp);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status)
            report_field("status", want.status, rsp.status);
          if (rsp.found_value !== want.found_value)
            report_field("found_value", want.found_value, rsp.found_value);
          if (rsp.last !== want.last)
            report_field("last", want.last, rsp.last);
          if (rsp.entry_count !== want.entry_count)
            report_field("entry_count", want.entry_count, rsp.entry_count);
          if (rsp.is_empty !== want.is_empty)
            report_field("is_empty", want.is_empty, rsp.is_empty);
        end
      end
      if (req_valid && !req_stall)
        predict_request(req);
    end
    fail_count <= mismatches;
    pending    <= expected_rsp.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the multimap table engine with directed requests, a back-pressure
// burst and random episodes of fill, mixed use and drain, with random idle
// cycles on both channels. The checker beside the block scores responses.
// ----------------------------------------------------------------------------
module tb_top
  import mte_pkg::*;
();

  localparam int CAPACITY        = CAPACITY_DEF;
  localparam int RANDOM_ITEMS    = 295;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 100;
  localparam int CYCLE_LIMIT     = 5000000;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int          fail_count;
  int          pending;
  int unsigned cycle_count   = 0;
  int          hold_requests = 0;
  int          items_sent    = 0;

  // pairs inserted under one-off keys, removed again by the drain episodes
  logic signed [31:0] loose_keys [$];
  logic signed [31:0] loose_vals [$];

  multimap_table_engine #(.CAPACITY(CAPACITY)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  mte_scoreboard #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned stall_burst();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 4);
    if (roll < 93) return $urandom_range(5, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [31:0] pool_key(int unsigned idx);
    case (idx)
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      default: return 32'sh5A5A_A5A5;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return pool_key($urandom_range(0, 5));
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
    return $urandom;
  endfunction

  // Hold the request until accepted, then idle for a random gap.
  task automatic send_request(kind_t kind, logic signed [31:0] key,
                              logic signed [31:0] value);
    req_t        r;
    int unsigned gap;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    gap = idle_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic insert_pair();
    logic signed [31:0] k;
    logic signed [31:0] v;
    v = pick_value();
    if ($urandom_range(0, 6) == 0) begin
      k = $urandom;
      loose_keys = {loose_keys, k};
      loose_vals = {loose_vals, v};
    end else begin
      k = pool_key($urandom_range(0, 5));
    end
    send_request(KIND_INSERT, k, v);
  endtask

  initial begin : rsp_side
    int holds_done;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        rsp_stall <= 1'b1;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        rsp_stall <= ($urandom_range(0, 2) == 0);
        repeat (stall_burst()) @(posedge clk);
      end
    end
  end

  initial begin : req_side
    int          random_start;
    int unsigned roll;
    int          p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: every lookup and removal misses
    send_request(KIND_SEARCH, 32'sd0, 32'sd0);
    send_request(KIND_REMOVE_PAIR, 32'sd0, 32'sd0);
    send_request(KIND_REMOVE_KEY, KEY_MIN, KEY_MAX);
    send_request(KIND_INSERT, KEY_MIN, KEY_MAX);
    send_request(KIND_INSERT, KEY_MAX, KEY_MIN);
    send_request(KIND_INSERT, 32'sd0, -32'sd1);
    send_request(KIND_INSERT, -32'sd1, 32'sd0);
    send_request(KIND_INSERT, KEY_MIN, 32'sd5);
    // duplicate pair is stored again
    send_request(KIND_INSERT, KEY_MIN, KEY_MAX);
    send_request(KIND_SEARCH, KEY_MIN, 32'sh5555_5555);
    send_request(KIND_SEARCH, 32'sd12345, -32'sd1);
    send_request(KIND_REMOVE_PAIR, KEY_MIN, KEY_MAX);
    send_request(KIND_REMOVE_PAIR, KEY_MIN, 32'sd7);
    send_request(KIND_SEARCH, KEY_MIN, 32'sd0);
    send_request(KIND_REMOVE_KEY, KEY_MIN, 32'shAAAA_AAAA);
    send_request(KIND_REMOVE_KEY, KEY_MIN, 32'sd0);
    send_request(KIND_SEARCH, KEY_MAX, 32'sd0);
    send_request(KIND_SEARCH, -32'sd1, KEY_MAX);
    send_request(KIND_REMOVE_PAIR, -32'sd1, 32'sd0);
    send_request(KIND_REMOVE_PAIR, 32'sd0, -32'sd1);
    send_request(KIND_REMOVE_PAIR, KEY_MAX, KEY_MIN);
    send_request(KIND_SEARCH, KEY_MAX, 32'sd0);

    // Stall responses for a long stretch while searches with many hits pile up.
    random_start = items_sent;
    hold_requests++;
    repeat (10) send_request(KIND_INSERT, pool_key(4), $urandom);
    repeat (3) send_request(KIND_SEARCH, pool_key(4), $urandom);
    send_request(KIND_REMOVE_KEY, pool_key(4), $urandom);

    while (items_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill past capacity so the last inserts are refused
          repeat (34) insert_pair();
          repeat (3) send_request(KIND_SEARCH, pick_key(), $urandom);
        end
        2, 3: begin
          while (loose_keys.size() != 0)
            send_request(KIND_REMOVE_PAIR, loose_keys.pop_front(), loose_vals.pop_front());
          for (p = 0; p < 6; p++) begin
            if ($urandom_range(0, 3) != 0)
              send_request(KIND_REMOVE_KEY, pool_key(p), $urandom);
            else
              send_request(KIND_SEARCH, pool_key(p), $urandom);
          end
        end
        default: begin
          repeat (20) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
              insert_pair();
            else if (roll < 70)
              send_request(KIND_SEARCH, pick_key(), $urandom);
            else if (roll < 85)
              send_request(KIND_REMOVE_PAIR, pick_key(), pick_value());
            else
              send_request(KIND_REMOVE_KEY, pick_key(), $urandom);
          end
        end
      endcase
    end

    req_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
